### rtl/bscc_pkg.sv
`default_nettype none

package bscc_pkg;

    // Widths of the configuration and stream fields
    localparam int CFG_W              = 16;
    localparam int CFG_IDX_W          = 2;
    localparam int TICK_COUNT_WIDTH_D = 16;
    localparam int S_DATA_W           = 8;
    localparam int M_DATA_W           = 64;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MAX  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_MIN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_HALF = 2'd3;

    // Configuration reset values
    localparam logic [CFG_W-1:0] SHORT_MIN_RST  = 16'd20;
    localparam logic [CFG_W-1:0] SHORT_MAX_RST  = 16'd800;
    localparam logic [CFG_W-1:0] LONG_MIN_RST   = 16'd1000;
    localparam logic [CFG_W-1:0] BLINK_HALF_RST = 16'd300;

    // Segment constants (active low, bit7 is the dot)
    localparam logic [7:0] SEG_BLANK    = 8'hFF;
    localparam logic [7:0] SEG_DOT_MASK = 8'h7F;
    localparam logic [7:0] SEG_DOT_OFF  = 8'h80;

    // Time limits
    localparam logic [5:0] SEC_LAST  = 6'd59;
    localparam logic [5:0] MIN_LAST  = 6'd59;
    localparam logic [4:0] HOUR_LAST = 5'd23;

    typedef enum logic [1:0] {
        MODE_DISPLAY  = 2'd0,
        MODE_MIN_SET  = 2'd1,
        MODE_HOUR_SET = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        EVT_NONE  = 2'd0,
        EVT_SHORT = 2'd1,
        EVT_LONG  = 2'd2
    } press_kind_t;

    // One result item; the last member sits in the lowest bits
    typedef struct packed {
        logic [5:0]  seconds_now;
        logic [5:0]  minutes_now;
        logic [4:0]  hours_now;
        press_kind_t key_event;
        mode_t       clock_mode;
        logic [3:0]  digit_enable;
        logic [7:0]  seg_hour_tens;
        logic [7:0]  seg_hour_units;
        logic [7:0]  seg_minute_tens;
        logic [7:0]  seg_minute_units;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

    // Decimal digit to active-low segments, blank for non-digits
    function automatic logic [7:0] digit_seg(input logic [3:0] d);
        logic [7:0] s;
        begin
            case (d)
                4'd0:    s = 8'hC0;
                4'd1:    s = 8'hF9;
                4'd2:    s = 8'hA4;
                4'd3:    s = 8'hB0;
                4'd4:    s = 8'h99;
                4'd5:    s = 8'h92;
                4'd6:    s = 8'h82;
                4'd7:    s = 8'hF8;
                4'd8:    s = 8'h80;
                4'd9:    s = 8'h90;
                default: s = SEG_BLANK;
            endcase
            return s;
        end
    endfunction

    // Tens digit of a value below 64 by a compare chain
    function automatic logic [2:0] tens_of(input logic [5:0] v);
        logic [2:0] t;
        begin
            if (v >= 6'd60)      t = 3'd6;
            else if (v >= 6'd50) t = 3'd5;
            else if (v >= 6'd40) t = 3'd4;
            else if (v >= 6'd30) t = 3'd3;
            else if (v >= 6'd20) t = 3'd2;
            else if (v >= 6'd10) t = 3'd1;
            else                 t = 3'd0;
            return t;
        end
    endfunction

    // Units digit given the value and its tens digit
    function automatic logic [3:0] units_of(input logic [5:0] v, input logic [2:0] t);
        logic [5:0] tens10;
        logic [5:0] u;
        begin
            tens10 = {t, 3'b000} + {2'b00, t, 1'b0};
            u      = v - tens10;
            return u[3:0];
        end
    endfunction

endpackage

`default_nettype wire

### rtl/bscc_core.sv
`default_nettype none

module bscc_core #(
    parameter int TICK_COUNT_WIDTH = bscc_pkg::TICK_COUNT_WIDTH_D
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       tick,
    input  wire logic                       key_down,
    input  wire logic                       second_pulse,
    input  wire logic [bscc_pkg::CFG_W-1:0] short_min,
    input  wire logic [bscc_pkg::CFG_W-1:0] short_max,
    input  wire logic [bscc_pkg::CFG_W-1:0] long_min,
    input  wire logic [bscc_pkg::CFG_W-1:0] blink_half,
    output bscc_pkg::result_t               result
);
    import bscc_pkg::*;

    localparam int CW = (TICK_COUNT_WIDTH > CFG_W) ? TICK_COUNT_WIDTH : CFG_W;

    mode_t                       mode_reg, mode_next;
    logic                        key_held_reg, key_held_next;
    logic [TICK_COUNT_WIDTH-1:0] press_reg, press_next;
    logic [CFG_W-1:0]            blink_ticks_reg, blink_ticks_next;
    logic                        blink_phase_reg, blink_phase_next;
    logic                        colon_reg, colon_next;
    logic [4:0]                  hours_reg, hours_next;
    logic [5:0]                  minutes_reg, minutes_next;
    logic [5:0]                  seconds_reg, seconds_next;

    press_kind_t                 evt;
    logic [CW-1:0]               dur;
    logic [CFG_W-1:0]            blink_inc;
    logic [3:0]                  enable;
    logic [2:0]                  min_t;
    logic [2:0]                  hr_t;
    logic [7:0]                  hu_seg;

    // State registers, loaded once per accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_DISPLAY;
            key_held_reg    <= 1'b0;
            press_reg       <= '0;
            blink_ticks_reg <= '0;
            blink_phase_reg <= 1'b0;
            colon_reg       <= 1'b0;
            hours_reg       <= '0;
            minutes_reg     <= '0;
            seconds_reg     <= '0;
        end
        else if (tick)
        begin
            mode_reg        <= mode_next;
            key_held_reg    <= key_held_next;
            press_reg       <= press_next;
            blink_ticks_reg <= blink_ticks_next;
            blink_phase_reg <= blink_phase_next;
            colon_reg       <= colon_next;
            hours_reg       <= hours_next;
            minutes_reg     <= minutes_next;
            seconds_reg     <= seconds_next;
        end
    end

    // Next state for one tick: time, blink, key, then mode
    always_comb
    begin
        mode_next        = mode_reg;
        key_held_next    = key_held_reg;
        press_next       = press_reg;
        colon_next       = colon_reg;
        hours_next       = hours_reg;
        minutes_next     = minutes_reg;
        seconds_next     = seconds_reg;
        evt              = EVT_NONE;
        dur              = CW'(press_reg);

        // time of day with carries
        if (second_pulse)
        begin
            colon_next = ~colon_reg;
            if (seconds_reg >= SEC_LAST)
            begin
                seconds_next = '0;
                if (minutes_reg >= MIN_LAST)
                begin
                    minutes_next = '0;
                    hours_next   = (hours_reg >= HOUR_LAST) ? 5'd0 : hours_reg + 5'd1;
                end
                else
                begin
                    minutes_next = minutes_reg + 6'd1;
                end
            end
            else
            begin
                seconds_next = seconds_reg + 6'd1;
            end
        end

        // setup blink timer
        blink_inc = blink_ticks_reg + 16'd1;
        if (blink_inc >= blink_half)
        begin
            blink_phase_next = ~blink_phase_reg;
            blink_ticks_next = '0;
        end
        else
        begin
            blink_phase_next = blink_phase_reg;
            blink_ticks_next = blink_inc;
        end

        // press timing, classified on release
        if (key_down && !key_held_reg)
        begin
            key_held_next = 1'b1;
            press_next    = TICK_COUNT_WIDTH'(1);
        end
        else if (key_down)
        begin
            if (press_reg != '1)
                press_next = press_reg + TICK_COUNT_WIDTH'(1);
        end
        else if (key_held_reg)
        begin
            if (dur >= CW'(long_min))
                evt = EVT_LONG;
            else if (dur >= CW'(short_min) && dur <= CW'(short_max))
                evt = EVT_SHORT;
            key_held_next = 1'b0;
            press_next    = '0;
        end

        // mode machine
        case (mode_reg)
            MODE_MIN_SET:
            begin
                if (evt == EVT_SHORT)
                    minutes_next = (minutes_next >= MIN_LAST) ? 6'd0 : minutes_next + 6'd1;
                else if (evt == EVT_LONG)
                    mode_next = MODE_HOUR_SET;
            end
            MODE_HOUR_SET:
            begin
                if (evt == EVT_SHORT)
                    hours_next = (hours_next >= HOUR_LAST) ? 5'd0 : hours_next + 5'd1;
                else if (evt == EVT_LONG)
                    mode_next = MODE_DISPLAY;
            end
            default:
            begin
                if (evt == EVT_LONG)
                    mode_next = MODE_MIN_SET;
            end
        endcase
    end

    // Display decode from the updated state
    always_comb
    begin
        enable = 4'hF;
        if (blink_phase_next)
        begin
            case (mode_next)
                MODE_MIN_SET:  enable = 4'hC;
                MODE_HOUR_SET: enable = 4'h3;
                default:       enable = 4'hF;
            endcase
        end

        min_t  = tens_of(minutes_next);
        hr_t   = tens_of({1'b0, hours_next});
        hu_seg = digit_seg(units_of({1'b0, hours_next}, hr_t));
        hu_seg = colon_next ? (hu_seg & SEG_DOT_MASK) : (hu_seg | SEG_DOT_OFF);

        result.seg_minute_units = digit_seg(units_of(minutes_next, min_t));
        result.seg_minute_tens  = digit_seg({1'b0, min_t});
        result.seg_hour_units   = hu_seg;
        result.seg_hour_tens    = (hr_t != 3'd0) ? digit_seg({1'b0, hr_t}) : SEG_BLANK;
        result.digit_enable     = enable;
        result.clock_mode       = mode_next;
        result.key_event        = evt;
        result.hours_now        = hours_next;
        result.minutes_now      = minutes_next;
        result.seconds_now      = seconds_next;
    end

endmodule

`default_nettype wire

### rtl/bscc_out_buf.sv
`default_nettype none

module bscc_out_buf #(
    parameter int WIDTH = bscc_pkg::RESULT_W
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output      logic             in_ready,
    input  wire logic [WIDTH-1:0] in_data,
    output      logic             out_valid,
    input  wire logic             out_ready,
    output      logic [WIDTH-1:0] out_data
);
    logic             out_valid_reg, out_valid_next;
    logic [WIDTH-1:0] out_data_reg, out_data_next;
    logic             skid_valid_reg, skid_valid_next;
    logic [WIDTH-1:0] skid_data_reg, skid_data_next;
    logic             in_fire;
    logic             out_fire;

    assign in_ready  = ~skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign in_fire   = in_valid & in_ready;
    assign out_fire  = out_valid_reg & out_ready;

    // Control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    // Output register plus one skid entry
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_fire)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else if (in_fire)
            begin
                out_data_next = in_data;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (in_fire)
        begin
            if (!out_valid_reg)
            begin
                out_data_next  = in_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = in_data;
                skid_valid_next = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/button_set_digital_clock_controller.sv
// Channel | Signals                          | Item
// s_      | s_tvalid s_tready s_tdata[7:0]   | one millisecond tick
// m_      | m_tvalid m_tready m_tdata[63:0]  | displays and time after that tick
// cfg_    | cfg_valid cfg_ready cfg_index    | one register write (cfg_data)
//
// One tick item is taken per clock while s_tready is high; its result is
// decoded combinationally from the tick state registers and that item, in front of
// the output register, and lands in the output register or in its skid entry; the
// output register and its skid entry let a new item in while a finished result waits.
// s_tready drops only when both output entries are full. cfg_ready is always high.
// Reset clears all time, key and mode state and loads the default thresholds.
`default_nettype none

module button_set_digital_clock_controller #(
    parameter int TICK_COUNT_WIDTH = bscc_pkg::TICK_COUNT_WIDTH_D
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output      logic                           s_tready,
    // [0] key_down, [1] second_pulse, [7:2] zero
    input  wire logic [bscc_pkg::S_DATA_W-1:0]  s_tdata,
    output      logic                           m_tvalid,
    input  wire logic                           m_tready,
    // [7:0] seg_minute_units, [15:8] seg_minute_tens, [23:16] seg_hour_units,
    // [31:24] seg_hour_tens, [35:32] digit_enable, [37:36] clock_mode,
    // [39:38] key_event, [44:40] hours_now, [50:45] minutes_now,
    // [56:51] seconds_now, [63:57] zero
    output      logic [bscc_pkg::M_DATA_W-1:0]  m_tdata,
    input  wire logic                           cfg_valid,
    output      logic                           cfg_ready,
    input  wire logic [bscc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bscc_pkg::CFG_W-1:0]     cfg_data
);
    import bscc_pkg::*;

    logic [CFG_W-1:0]    short_min_reg;
    logic [CFG_W-1:0]    short_max_reg;
    logic [CFG_W-1:0]    long_min_reg;
    logic [CFG_W-1:0]    blink_half_reg;
    logic                tick;
    result_t             result;
    logic [RESULT_W-1:0] buf_data;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_min_reg  <= SHORT_MIN_RST;
            short_max_reg  <= SHORT_MAX_RST;
            long_min_reg   <= LONG_MIN_RST;
            blink_half_reg <= BLINK_HALF_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SHORT_MIN:  short_min_reg  <= cfg_data;
                CFG_SHORT_MAX:  short_max_reg  <= cfg_data;
                CFG_LONG_MIN:   long_min_reg   <= cfg_data;
                CFG_BLINK_HALF: blink_half_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign tick = s_tvalid & s_tready;

    bscc_core #(
        .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick         (tick),
        .key_down     (s_tdata[0]),
        .second_pulse (s_tdata[1]),
        .short_min    (short_min_reg),
        .short_max    (short_max_reg),
        .long_min     (long_min_reg),
        .blink_half   (blink_half_reg),
        .result       (result)
    );

    bscc_out_buf #(
        .WIDTH (RESULT_W)
    ) u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (buf_data)
    );

    assign m_tdata = {{(M_DATA_W - RESULT_W){1'b0}}, buf_data};

endmodule

`default_nettype wire

### rtl/bscc_checker.sv
`default_nettype none

module bscc_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [bscc_pkg::M_DATA_W-1:0]  m_tdata
);
    import bscc_pkg::*;

    // A stalled result item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    // Input stalls only with a result pending
    a_stall_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

    // Time fields stay in range
    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[44:40] <= 5'd23 && m_tdata[50:45] <= 6'd59
                     && m_tdata[56:51] <= 6'd59)
        else $error("time out of range");

    // Display mode never blanks a digit
    a_display_enables: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[37:36] == MODE_DISPLAY |-> m_tdata[35:32] == 4'hF)
        else $error("digit blanked in display mode");

    // Leading hour zero is blanked
    a_hour_blank: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[44:40] < 5'd10 |-> m_tdata[31:24] == SEG_BLANK)
        else $error("leading hour zero not blanked");

endmodule

bind button_set_digital_clock_controller bscc_checker u_bscc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);

`default_nettype wire

### tb/sv/button_set_digital_clock_controller_test.sv
`timescale 1ns / 1ps

module button_set_digital_clock_controller_test;

    import bscc_pkg::*;

    // Tracks clock, key and mode state and the displays each tick should give
    class clock_tracker;
        logic [CFG_W-1:0]              short_min;
        logic [CFG_W-1:0]              short_max;
        logic [CFG_W-1:0]              long_min;
        logic [CFG_W-1:0]              blink_half;
        mode_t                         mode;
        bit                            held;
        logic [TICK_COUNT_WIDTH_D-1:0] press_cnt;
        logic [CFG_W-1:0]              blink_cnt;
        bit                            blink_on;
        bit                            colon_on;
        logic [4:0]                    hours;
        logic [5:0]                    minutes;
        logic [5:0]                    seconds;
        result_t                       due_displays[$];
        int                            failures;

        function new();
            short_min  = SHORT_MIN_RST;
            short_max  = SHORT_MAX_RST;
            long_min   = LONG_MIN_RST;
            blink_half = BLINK_HALF_RST;
            mode       = MODE_DISPLAY;
            held       = 1'b0;
            press_cnt  = '0;
            blink_cnt  = '0;
            blink_on   = 1'b0;
            colon_on   = 1'b0;
            hours      = '0;
            minutes    = '0;
            seconds    = '0;
            failures   = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_SHORT_MIN:  short_min  = val;
                CFG_SHORT_MAX:  short_max  = val;
                CFG_LONG_MIN:   long_min   = val;
                CFG_BLINK_HALF: blink_half = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return due_displays.size();
        endfunction

        // Active-low seven-segment code of one decimal digit
        function logic [7:0] seg_pattern(int d);
            case (d)
                0:       return 8'hC0;
                1:       return 8'hF9;
                2:       return 8'hA4;
                3:       return 8'hB0;
                4:       return 8'h99;
                5:       return 8'h92;
                6:       return 8'h82;
                7:       return 8'hF8;
                8:       return 8'h80;
                9:       return 8'h90;
                default: return SEG_BLANK;
            endcase
        endfunction

        // Advance one millisecond tick and queue the display it gives
        function void note_tick(bit key, bit pulse);
            press_kind_t ev;
            logic [3:0]  en;
            logic [7:0]  hu;
            result_t     r;
            ev = EVT_NONE;
            en = 4'hF;

            // time of day with carries
            if (pulse)
            begin
                colon_on = ~colon_on;
                if (seconds >= SEC_LAST)
                begin
                    seconds = '0;
                    if (minutes >= MIN_LAST)
                    begin
                        minutes = '0;
                        hours   = (hours >= HOUR_LAST) ? 5'd0 : hours + 5'd1;
                    end
                    else
                        minutes = minutes + 6'd1;
                end
                else
                    seconds = seconds + 6'd1;
            end

            // setup blink
            blink_cnt = blink_cnt + CFG_W'(1);
            if (blink_cnt >= blink_half)
            begin
                blink_on  = ~blink_on;
                blink_cnt = '0;
            end

            // press timing, classified on release
            if (key && !held)
            begin
                held      = 1'b1;
                press_cnt = TICK_COUNT_WIDTH_D'(1);
            end
            else if (key)
            begin
                if (press_cnt != '1)
                    press_cnt = press_cnt + TICK_COUNT_WIDTH_D'(1);
            end
            else if (held)
            begin
                if (press_cnt >= short_min && press_cnt <= short_max)
                    ev = EVT_SHORT;
                if (press_cnt >= long_min)
                    ev = EVT_LONG;
                held      = 1'b0;
                press_cnt = '0;
            end

            // mode machine
            case (mode)
                MODE_MIN_SET:
                begin
                    if (ev == EVT_SHORT)
                        minutes = (minutes >= MIN_LAST) ? 6'd0 : minutes + 6'd1;
                    else if (ev == EVT_LONG)
                        mode = MODE_HOUR_SET;
                end
                MODE_HOUR_SET:
                begin
                    if (ev == EVT_SHORT)
                        hours = (hours >= HOUR_LAST) ? 5'd0 : hours + 5'd1;
                    else if (ev == EVT_LONG)
                        mode = MODE_DISPLAY;
                end
                default:
                begin
                    if (ev == EVT_LONG)
                        mode = MODE_MIN_SET;
                end
            endcase

            if (blink_on)
            begin
                if (mode == MODE_MIN_SET)
                    en = en & 4'b1100;
                else if (mode == MODE_HOUR_SET)
                    en = en & 4'b0011;
            end

            hu = seg_pattern(hours % 10);
            hu = colon_on ? (hu & SEG_DOT_MASK) : (hu | SEG_DOT_OFF);

            r.seg_minute_units = seg_pattern(minutes % 10);
            r.seg_minute_tens  = seg_pattern(minutes / 10);
            r.seg_hour_units   = hu;
            r.seg_hour_tens    = (hours / 10 != 0) ? seg_pattern(hours / 10) : SEG_BLANK;
            r.digit_enable     = en;
            r.clock_mode       = mode;
            r.key_event        = ev;
            r.hours_now        = hours;
            r.minutes_now      = minutes;
            r.seconds_now      = seconds;
            due_displays.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s expected 0x%0h actual 0x%0h", name, want, got);
                failures++;
            end
        endfunction

        // Compare one display item with the oldest one due
        function void check_display(result_t got);
            result_t want;
            if (due_displays.size() == 0)
            begin
                $error("display item with none due: 0x%0h", got);
                failures++;
                return;
            end
            want = due_displays.pop_front();
            compare_field("seg_minute_units", want.seg_minute_units, got.seg_minute_units);
            compare_field("seg_minute_tens", want.seg_minute_tens, got.seg_minute_tens);
            compare_field("seg_hour_units", want.seg_hour_units, got.seg_hour_units);
            compare_field("seg_hour_tens", want.seg_hour_tens, got.seg_hour_tens);
            compare_field("digit_enable", want.digit_enable, got.digit_enable);
            compare_field("clock_mode", want.clock_mode, got.clock_mode);
            compare_field("key_event", want.key_event, got.key_event);
            compare_field("hours_now", want.hours_now, got.hours_now);
            compare_field("minutes_now", want.minutes_now, got.minutes_now);
            compare_field("seconds_now", want.seconds_now, got.seconds_now);
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_SHORT_MIN;
    logic [CFG_W-1:0]      cfg_data = '0;

    clock_tracker tracker;
    bit           burst = 1'b0;
    int           stall_left = 0;
    int           ticks_sent = 0;

    button_set_digital_clock_controller u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // Idle cycles before the next item; none during a burst
    function automatic int idle_draw();
        return burst ? 0 : $urandom_range(0, 3);
    endfunction

    // Display side: random stall after each item, check every accepted item
    always @(posedge clk or negedge rst_n)
    begin
        int n;
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end
        else if (m_tvalid && m_tready)
        begin
            tracker.check_display(result_t'(m_tdata[RESULT_W-1:0]));
            n = idle_draw();
            m_tready   <= (n == 0);
            stall_left <= n - 1;
        end
        else if (!m_tready)
        begin
            if (stall_left <= 0)
                m_tready <= 1'b1;
            else
                stall_left <= stall_left - 1;
        end
    end

    // One tick item; returns just after the edge that took it
    task automatic tick(input bit key, input bit pulse);
        int gap;
        gap = idle_draw();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W-2){1'b0}}, pulse, key};
        do @(posedge clk); while (!s_tready);
        tracker.note_tick(key, pulse);
        ticks_sent++;
    endtask

    // Key held for hold ticks then released for rest ticks
    task automatic press(input int hold, input int rest, input bit pulses);
        int i;
        for (i = 0; i < hold + rest; i++)
            tick(i < hold, pulses ? 1'($urandom_range(0, 1)) : 1'b0);
    endtask

    // Stop sending until every due display item has come back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (tracker.pending() != 0) @(negedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_regs(input logic [CFG_W-1:0] smin, input logic [CFG_W-1:0] smax,
                              input logic [CFG_W-1:0] lmin, input logic [CFG_W-1:0] blink);
        logic [CFG_IDX_W-1:0] idx [4];
        logic [CFG_W-1:0]     val [4];
        int                   i;
        idx = '{CFG_SHORT_MIN, CFG_SHORT_MAX, CFG_LONG_MIN, CFG_BLINK_HALF};
        val = '{smin, smax, lmin, blink};
        for (i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do @(posedge clk); while (!cfg_ready);
            tracker.set_reg(idx[i], val[i]);
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Press length mostly aimed at a threshold edge, kept short
    function automatic int pick_hold();
        int v;
        case ($urandom_range(0, 7))
            0:       v = int'(tracker.short_min) - 1;
            1:       v = int'(tracker.short_min);
            2:       v = int'(tracker.short_max);
            3:       v = int'(tracker.short_max) + 1;
            4:       v = int'(tracker.long_min) - 1;
            5:       v = int'(tracker.long_min);
            6:       v = int'(tracker.long_min) + 1;
            default: v = $urandom_range(1, 20);
        endcase
        if (v < 1)
            v = 1;
        if (v > 40)
            v = 40;
        return v;
    endfunction

    // Mostly well-formed presses, some raw key noise, bursts and drains
    task automatic run_random(input int count);
        int stop_at;
        int i;
        int n;
        stop_at = ticks_sent + count;
        while (ticks_sent < stop_at)
        begin
            if ($urandom_range(0, 15) == 0)
                burst <= ~burst;
            if ($urandom_range(0, 39) == 0)
                wait_idle();
            if ($urandom_range(0, 7) == 0)
            begin
                n = $urandom_range(1, 6);
                for (i = 0; i < n; i++)
                    tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
            else
                press(pick_hold(), $urandom_range(1, 4), 1'b1);
        end
        burst <= 1'b0;
    endtask

    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int len;
        int ph;
        tracker = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset thresholds: just below the short window, then at its floor
        press(19, 2, 1'b1);
        press(20, 2, 1'b1);
        press(3, 1, 1'b1);
        wait_idle();

        // below short, short, gap, long; then hour setup bumps and back
        write_regs(16'd2, 16'd3, 16'd5, 16'd1);
        for (len = 1; len <= 6; len++)
            press(len, 2, 1'b1);
        press(2, 1, 1'b1);
        press(3, 1, 1'b1);
        press(5, 1, 1'b1);
        wait_idle();

        // blink every tick; set 23:59 by hand, then roll the day over
        write_regs(16'd1, 16'd1, 16'd2, 16'd0);
        while (tracker.mode != MODE_MIN_SET)
            press(2, 1, 1'b0);
        while (tracker.minutes != MIN_LAST)
            press(1, 1, 1'b0);
        press(2, 1, 1'b0);
        while (tracker.hours != HOUR_LAST)
            press(1, 1, 1'b0);
        press(2, 1, 1'b0);
        repeat (60 - int'(tracker.seconds)) tick(1'b0, 1'b1);
        tick(1'b0, 1'b0);
        wait_idle();

        // all thresholds at top: a short hold falls below the short window
        write_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        press(3, 2, 1'b1);
        wait_idle();

        // random phases over several threshold settings
        for (ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0:       write_regs(16'd0, 16'd0, 16'd0, 16'd1);
                1:       write_regs(16'd0, 16'hFFFF, 16'hFFFF, 16'($urandom_range(1, 20)));
                default: write_regs(16'($urandom_range(0, 4)), 16'($urandom_range(0, 12)),
                                    16'($urandom_range(0, 16)), 16'($urandom_range(0, 20)));
            endcase
            run_random(125);
            wait_idle();
        end

        repeat (8) @(posedge clk);
        if (tracker.failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### button_set_digital_clock_controller.f
rtl/bscc_pkg.sv
rtl/bscc_core.sv
rtl/bscc_out_buf.sv
rtl/button_set_digital_clock_controller.sv
rtl/bscc_checker.sv
tb/sv/button_set_digital_clock_controller_test.sv
